@@ hw/rtl/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 decoder with BOM strip.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned StW   = 3;
  localparam int unsigned RemW  = 2;

  localparam logic [CpW-1:0] BomCodepoint = 21'h00FEFF;

  typedef enum logic [StW-1:0] {
    ST_CODEPOINT    = 3'd0,
    ST_END          = 3'd1,
    ST_UNEXP_CONT   = 3'd2,
    ST_INVALID_CONT = 3'd3,
    ST_TRUNCATED    = 3'd4,
    ST_BAD_LEAD     = 3'd5
  } status_e;

  typedef struct packed {
    logic [CpW-1:0] codepoint;
    status_e        status;
  } result_t;

  typedef struct packed {
    logic [CpW-1:0]  acc;
    logic [RemW-1:0] rem;
    logic            armed;
  } dec_state_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_out_t;

endpackage

@@ hw/rtl/u8d_in_if.sv @@
// ----------------------------------------------------------------------------
// u8d_in_if
// Byte request channel: one raw byte or an end-of-input marker.
// ----------------------------------------------------------------------------
interface u8d_in_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::ByteW-1:0] data_byte;
  logic                      end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

@@ hw/rtl/u8d_out_if.sv @@
// ----------------------------------------------------------------------------
// u8d_out_if
// Result channel: a codepoint, an end marker or an error code.
// ----------------------------------------------------------------------------
interface u8d_out_if;
  logic                    valid;
  logic                    ready;
  logic [u8d_pkg::CpW-1:0] codepoint;
  u8d_pkg::status_e        status;

  modport source (output valid, output codepoint, output status, input ready);
  modport sink   (input valid, input codepoint, input status, output ready);
endinterface

@@ hw/rtl/u8d_cfg_if.sv @@
// ----------------------------------------------------------------------------
// u8d_cfg_if
// Configuration write channel for the strip_bom register.
// ----------------------------------------------------------------------------
interface u8d_cfg_if;
  logic valid;
  logic ready;
  logic strip_bom;

  modport source (output valid, output strip_bom, input ready);
  modport sink   (input valid, input strip_bom, output ready);
endinterface

@@ hw/rtl/u8d_step.sv @@
// ----------------------------------------------------------------------------
// u8d_step
// Decode step: next decoder state and optional result for one input byte or end marker.
// ----------------------------------------------------------------------------
module u8d_step (
  input  u8d_pkg::dec_state_t         state_i,
  input  logic [u8d_pkg::ByteW-1:0]   data_byte_i,
  input  logic                        end_of_input_i,
  output u8d_pkg::dec_state_t         state_o,
  output u8d_pkg::step_out_t          out_o
);
  import u8d_pkg::*;

  logic [ByteW-1:0] cont;
  logic [CpW-1:0]   shifted;
  logic             fin;
  logic [CpW-1:0]   fin_cp;

  assign cont    = data_byte_i ^ 8'h80;
  assign shifted = {state_i.acc[CpW-7:0], cont[5:0]};

  always_comb begin
    state_o          = state_i;
    out_o.emit       = 1'b0;
    out_o.res.codepoint = '0;
    out_o.res.status    = ST_CODEPOINT;
    fin    = 1'b0;
    fin_cp = '0;

    if (end_of_input_i) begin
      out_o.emit = 1'b1;
      if (state_i.rem != '0) begin
        state_o.rem      = '0;
        state_o.acc      = '0;
        out_o.res.status = ST_TRUNCATED;
      end else begin
        state_o.armed    = 1'b0;
        out_o.res.status = ST_END;
      end
    end else if (state_i.rem != '0) begin
      if (cont[7:6] != 2'b00) begin
        // not a continuation: drop the pending sequence
        state_o.rem      = '0;
        state_o.acc      = '0;
        out_o.emit       = 1'b1;
        out_o.res.status = ST_INVALID_CONT;
      end else begin
        state_o.acc = shifted;
        state_o.rem = state_i.rem - 2'd1;
        if (state_i.rem == 2'd1) begin
          fin    = 1'b1;
          fin_cp = shifted;
        end
      end
    end else if (data_byte_i inside {[8'h00:8'h7F]}) begin
      fin    = 1'b1;
      fin_cp = {{(CpW-ByteW){1'b0}}, data_byte_i};
    end else if (data_byte_i inside {[8'h80:8'hBF]}) begin
      out_o.emit       = 1'b1;
      out_o.res.status = ST_UNEXP_CONT;
    end else if (data_byte_i inside {[8'hC0:8'hDF]}) begin
      state_o.acc = {{(CpW-5){1'b0}}, data_byte_i[4:0]};
      state_o.rem = 2'd1;
    end else if (data_byte_i inside {[8'hE0:8'hEF]}) begin
      state_o.acc = {{(CpW-4){1'b0}}, data_byte_i[3:0]};
      state_o.rem = 2'd2;
    end else if (data_byte_i inside {[8'hF0:8'hF7]}) begin
      state_o.acc = {{(CpW-3){1'b0}}, data_byte_i[2:0]};
      state_o.rem = 2'd3;
    end else begin
      out_o.emit       = 1'b1;
      out_o.res.status = ST_BAD_LEAD;
    end

    if (fin) begin
      // first decoded codepoint disarms the check; drop it if it is the mark
      state_o.armed       = 1'b0;
      out_o.emit          = !(state_i.armed && (fin_cp == BomCodepoint));
      out_o.res.codepoint = fin_cp;
      out_o.res.status    = ST_CODEPOINT;
    end
  end

endmodule

@@ hw/rtl/u8d_out_reg.sv @@
// ----------------------------------------------------------------------------
// u8d_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module u8d_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  u8d_pkg::result_t res_i,
  output logic             can_load_o,
  output logic             valid_o,
  input  logic             ready_i,
  output u8d_pkg::result_t res_o
);
  import u8d_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ hw/rtl/utf8_decoder_with_bom_strip_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_decoder_with_bom_strip_unit
// Lax UTF-8 decoder with optional removal of a leading byte order mark.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | request
//  --------+-----+------------------------------+-------------------------
//  in_i    | in  | data_byte[7:0], end_of_input | one byte or end marker
//  out_o   | out | codepoint[20:0], status[2:0] | one result
//  cfg_i   | in  | strip_bom                    | write of strip_bom
//
//  One byte is accepted per cycle unless a result stalls; a byte's result
//  goes from the input register through decode into the result register.
//  The decoder state register feeds back only through the single decode step.
//  Reset clears the pending sequence and arms the BOM check.
//  A stalled result register holds an input byte that has a result, so ready drops.
// ----------------------------------------------------------------------------
module utf8_decoder_with_bom_strip_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  u8d_in_if.sink     in_i,
  u8d_out_if.source  out_o,
  u8d_cfg_if.sink    cfg_i
);
  import u8d_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] byte_q;
  logic             eoi_q;
  dec_state_t       state_q, state_d, step_state;
  step_out_t        step;
  logic             can_load;
  logic             adv;
  logic             in_fire;
  logic             cfg_fire;
  result_t          out_res;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // advance when the result register can take the decoded byte's result or it needs no slot
  assign adv         = in_valid_q && (!step.emit || can_load);
  assign in_i.ready  = !in_valid_q || adv;
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_valid_d  = in_fire || (in_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_i.data_byte;
      eoi_q  <= in_i.end_of_input;
    end
  end

  u8d_step u_step (
    .state_i        (state_q),
    .data_byte_i    (byte_q),
    .end_of_input_i (eoi_q),
    .state_o        (step_state),
    .out_o          (step)
  );

  always_comb begin
    state_d = state_q;
    if (adv) begin
      state_d = step_state;
    end
    if (cfg_fire) begin
      state_d.armed = cfg_i.strip_bom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.acc   <= '0;
      state_q.rem   <= '0;
      state_q.armed <= 1'b1;
    end else begin
      state_q <= state_d;
    end
  end

  u8d_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (adv && step.emit),
    .res_i      (step.res),
    .can_load_o (can_load),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .res_o      (out_res)
  );

  assign out_o.codepoint = out_res.codepoint;
  assign out_o.status    = out_res.status;

  // an aborted sequence leaves nothing pending
  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step.emit &&
    (step.res.status == ST_TRUNCATED || step.res.status == ST_INVALID_CONT)
    |=> state_q.rem == '0)
    else $error("pending sequence survived an error");

  // end of input with nothing pending disarms the BOM check
  a_end_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step.emit && step.res.status == ST_END && !cfg_fire
    |=> !state_q.armed)
    else $error("BOM check still armed after end of input");

  // only a codepoint result carries a nonzero codepoint
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_CODEPOINT |-> out_o.codepoint == '0)
    else $error("error or end result carries a codepoint");

  // a byte waiting in the input register is never lost
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(byte_q) && $stable(eoi_q))
    else $error("stalled input byte was lost");

  // a decoded result is loaded only into a free result register
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step.emit |-> !out_o.valid || out_o.ready)
    else $error("result register overrun");

endmodule

@@ dv/utf8_decode_checker.sv @@
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches the byte, result and configuration channels of the decoder. It
// decodes each accepted byte with its own copy of the decoder state, queues
// the result that byte should cause, and compares every accepted result
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module utf8_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8d_in_if           in_mon_i,
  u8d_out_if          out_mon_i,
  u8d_cfg_if          cfg_mon_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import u8d_pkg::*;

  localparam logic [ByteW-1:0] ContFlip  = 8'h80;
  localparam logic [ByteW-1:0] LeadTwo   = 8'hC0;
  localparam logic [ByteW-1:0] LeadThree = 8'hE0;
  localparam logic [ByteW-1:0] LeadFour  = 8'hF0;
  localparam logic [ByteW-1:0] LeadBad   = 8'hF8;

  logic [CpW-1:0]  acc_q;
  logic [RemW-1:0] rem_q;
  logic            armed_q;
  result_t         due_results[$];
  int unsigned     mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Close a codepoint; swallow it when it is the first one and a BOM.
  function automatic bit close_codepoint(input logic [CpW-1:0] cp, output result_t r);
    if (armed_q) begin
      armed_q = 1'b0;
      if (cp == BomCodepoint) return 1'b0;
    end
    r.codepoint = cp;
    r.status    = ST_CODEPOINT;
    return 1'b1;
  endfunction

  // Advance the decoder by one byte or end marker; 1 when a result is due.
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic eoi,
                                     output result_t r);
    logic [ByteW-1:0] c;
    r.codepoint = '0;
    r.status    = ST_CODEPOINT;
    if (eoi) begin
      if (rem_q != '0) begin
        rem_q    = '0;
        acc_q    = '0;
        r.status = ST_TRUNCATED;
        return 1'b1;
      end
      armed_q  = 1'b0;
      r.status = ST_END;
      return 1'b1;
    end
    if (rem_q != '0) begin
      c = b ^ ContFlip;
      if (c[7:6] != 2'b00) begin
        rem_q    = '0;
        acc_q    = '0;
        r.status = ST_INVALID_CONT;
        return 1'b1;
      end
      acc_q = {acc_q[CpW-7:0], c[5:0]};
      rem_q = rem_q - 1'b1;
      if (rem_q == '0) return close_codepoint(acc_q, r);
      return 1'b0;
    end
    if (b < ContFlip) return close_codepoint({13'd0, b}, r);
    if (b < LeadTwo) begin
      r.status = ST_UNEXP_CONT;
      return 1'b1;
    end
    if (b < LeadThree) begin
      acc_q = {16'd0, b[4:0]};
      rem_q = 2'd1;
      return 1'b0;
    end
    if (b < LeadFour) begin
      acc_q = {17'd0, b[3:0]};
      rem_q = 2'd2;
      return 1'b0;
    end
    if (b < LeadBad) begin
      acc_q = {18'd0, b[2:0]};
      rem_q = 2'd3;
      return 1'b0;
    end
    r.status = ST_BAD_LEAD;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    bit      emits;
    if (!rst_ni) begin
      acc_q   = '0;
      rem_q   = '0;
      armed_q = 1'b1;
      due_results.delete();
    end else begin
      // Retire before queueing: a result never belongs to the byte of its own cycle.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unrequested result: codepoint %06h status %0d",
                                    out_mon_i.codepoint, out_mon_i.status));
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (out_mon_i.codepoint !== want.codepoint)
            report_mismatch($sformatf("codepoint %06h, want %06h",
                                      out_mon_i.codepoint, want.codepoint));
          if (out_mon_i.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_mon_i.status, want.status));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        emits = decode_byte(in_mon_i.data_byte, in_mon_i.end_of_input, want);
        if (emits) due_results.insert(due_results.size(), want);
      end
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        armed_q = cfg_mon_i.strip_bom;
      end
    end
    fail_cnt_o <= mismatches;
    pending_o  <= unsigned'(due_results.size());
  end

endmodule

@@ dv/tb_utf8_decoder_with_bom_strip_unit.sv @@
// ----------------------------------------------------------------------------
// tb_utf8_decoder_with_bom_strip_unit
// Drives byte streams into the UTF-8 decoder: a directed opening with BOM,
// extreme, error and end cases, then phases of random well-formed sequences
// mixed with noise and broken sequences, each phase under its own strip_bom
// setting and idle pattern. A side checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_utf8_decoder_with_bom_strip_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned PhaseItems  = 60;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned SettleCycles = 4;
  localparam logic [7:0]  ContMark    = 8'h80;
  localparam logic [7:0]  BadLeadBase = 8'hF8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned sent_cnt;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  u8d_in_if  in_ch();
  u8d_out_if out_ch();
  u8d_cfg_if cfg_ch();

  utf8_decoder_with_bom_strip_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  utf8_decode_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon_i   (in_ch),
    .out_mon_i  (out_ch),
    .cfg_mon_i  (cfg_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("utf8_decoder_with_bom_strip_unit regression: fail");
        $finish;
      end
    end
  end

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Lead byte of an n-byte sequence with random payload.
  function automatic logic [7:0] lead_for(input int unsigned n);
    case (n)
      1:       return 8'($urandom_range(0, 127));
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return ContMark | 8'($urandom_range(0, 63));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    @(negedge clk_i);
    while (roll(send_idle_pct)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_bom();
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // Drop the request and hold until every queued result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  task automatic write_strip(input logic v);
    wait_drained();
    // Let a swallowed BOM still in flight leave the pipeline.
    repeat (SettleCycles) @(negedge clk_i);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.strip_bom <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_unit();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      n = $urandom_range(1, 4);
      send_byte(lead_for(n), 1'b0);
      repeat (n - 1) send_byte(cont_byte(), 1'b0);
    end else if (pick < 62) begin
      send_bom();
    end else if (pick < 77) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 92) begin
      // Cut a sequence short and break it with a non-continuation or an end marker.
      n = $urandom_range(2, 4);
      send_byte(lead_for(n), 1'b0);
      repeat ($urandom_range(0, n - 2)) send_byte(cont_byte(), 1'b0);
      case ($urandom_range(0, 3))
        0:       send_byte(lead_for(1), 1'b0);
        1:       send_byte(lead_for($urandom_range(2, 4)), 1'b0);
        2:       send_byte(BadLeadBase | 8'($urandom_range(0, 7)), 1'b0);
        default: send_byte(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int unsigned target;
    bit          drained;
    logic        strip_val;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.strip_bom   = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    sent_cnt           = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Armed out of reset: the first BOM is dropped, the second one is not.
    send_bom();
    send_bom();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    // Largest codepoint the lax decoder can build.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // ASCII where a continuation is due.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    // End inside a sequence, then end with nothing pending.
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);

    for (int p = 0; p < PhaseCount; p++) begin
      strip_val = (p % 2 == 1);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      write_strip(strip_val);
      target  = sent_cnt + PhaseItems;
      drained = 1'b0;
      if (strip_val && roll(50)) send_bom();
      while (sent_cnt < target) begin
        if (!drained && sent_cnt + PhaseItems / 2 >= target) begin
          wait_drained();
          drained = 1'b1;
        end
        send_random_unit();
      end
    end

    wait_drained();
    repeat (2 * SettleCycles) @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("utf8_decoder_with_bom_strip_unit regression: pass");
    end else begin
      $display("utf8_decoder_with_bom_strip_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_in_if.sv
hw/rtl/u8d_out_if.sv
hw/rtl/u8d_cfg_if.sv
hw/rtl/u8d_step.sv
hw/rtl/u8d_out_reg.sv
hw/rtl/utf8_decoder_with_bom_strip_unit.sv
dv/utf8_decode_checker.sv
dv/tb_utf8_decoder_with_bom_strip_unit.sv
